[hw/rtl/epd_pkg.sv]
// ----------------------------------------------------------------------------
// epd_pkg
// Shared types and constants for the embedding pair distance block.
// ----------------------------------------------------------------------------
package epd_pkg;

  localparam int unsigned Lanes = 4;

  localparam logic [17:0] OneQ16 = 18'd65536;
  localparam logic [17:0] TwoQ16 = 18'd131072;

  // products of one lane for one group
  typedef struct packed {
    logic [31:0] sq;  // (a-b)^2, unsigned
    logic [31:0] dp;  // a*b, two's complement
    logic [30:0] na;  // a*a, unsigned
    logic [30:0] nb;  // b*b, unsigned
  } lane_prod_t;

  // accumulator set
  typedef struct packed {
    logic [39:0] sq;  // unsigned
    logic [39:0] dot; // two's complement
    logic [38:0] na;  // unsigned
    logic [38:0] nb;  // unsigned
  } acc_t;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StWProd = 9'b000000010,
    StWDiv  = 9'b000000100,
    StWMul  = 9'b000001000,
    StNorm  = 9'b000010000,
    StSqrt  = 9'b000100000,
    StSMul  = 9'b001000000,
    StCDiv  = 9'b010000000,
    StDone  = 9'b100000000
  } fin_state_e;

endpackage

[hw/rtl/epd_lane.sv]
// ----------------------------------------------------------------------------
// epd_lane
// One element lane: squared difference, cross product and both squares.
// ----------------------------------------------------------------------------
module epd_lane (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [15:0]  first_i,
  input  logic signed [15:0]  second_i,
  output epd_pkg::lane_prod_t prod_o
);
  import epd_pkg::*;

  logic signed [16:0] diff;
  lane_prod_t         prod_d, prod_q;

  always_comb begin
    diff      = 17'(first_i) - 17'(second_i);
    prod_d.sq = 32'(diff * diff);
    prod_d.dp = 32'(first_i * second_i);
    prod_d.na = 31'(first_i * first_i);
    prod_d.nb = 31'(second_i * second_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

[hw/rtl/epd_merge.sv]
// ----------------------------------------------------------------------------
// epd_merge
// Sum the lane products and update the saturating accumulators.
// ----------------------------------------------------------------------------
module epd_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic                last_i,
  input  epd_pkg::lane_prod_t prod_i [epd_pkg::Lanes],
  output epd_pkg::acc_t       acc_o
);
  import epd_pkg::*;

  acc_t               acc_d, acc_q;
  logic [33:0]        sq_sum;
  logic signed [33:0] dp_sum;
  logic [32:0]        na_sum, nb_sum;
  logic [40:0]        sq_w;
  logic signed [40:0] dot_w;
  logic [39:0]        na_w, nb_w;

  always_comb begin
    sq_sum = '0;
    dp_sum = '0;
    na_sum = '0;
    nb_sum = '0;
    for (int i = 0; i < Lanes; i++) begin
      sq_sum = sq_sum + 34'(prod_i[i].sq);
      dp_sum = dp_sum + 34'($signed(prod_i[i].dp));
      na_sum = na_sum + 33'(prod_i[i].na);
      nb_sum = nb_sum + 33'(prod_i[i].nb);
    end

    sq_w  = {1'b0, acc_q.sq} + 41'(sq_sum);
    dot_w = 41'($signed(acc_q.dot)) + 41'(dp_sum);
    na_w  = {1'b0, acc_q.na} + 40'(na_sum);
    nb_w  = {1'b0, acc_q.nb} + 40'(nb_sum);

    acc_d.sq = sq_w[40] ? '1 : sq_w[39:0];
    priority if (!dot_w[40] && dot_w[39]) begin
      acc_d.dot = {1'b0, {39{1'b1}}};
    end else if (dot_w[40] && !dot_w[39]) begin
      acc_d.dot = {1'b1, 39'b0};
    end else begin
      acc_d.dot = dot_w[39:0];
    end
    acc_d.na = na_w[39] ? '1 : na_w[38:0];
    acc_d.nb = nb_w[39] ? '1 : nb_w[38:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (valid_i) begin
      acc_q <= last_i ? '0 : acc_d;
    end
  end

  assign acc_o = acc_d;

endmodule

[hw/rtl/epd_final.sv]
// ----------------------------------------------------------------------------
// epd_final
// Per-pair sequencer: Ward weighting, norm roots and cosine division.
// ----------------------------------------------------------------------------
module epd_final (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  epd_pkg::acc_t      acc_i,
  input  logic [15:0]        weight_first_i,
  input  logic [15:0]        weight_second_i,
  output logic               busy_o,
  output logic               valid_o,
  output logic [39:0]        sq_dist_o,
  output logic [47:0]        ward_dist_o,
  output logic signed [39:0] dot_product_o,
  output logic [38:0]        norm_sq_first_o,
  output logic [17:0]        cosine_dist_o,
  output logic [17:0]        unit_cosine_dist_o,
  output logic               weight_sum_zero_o,
  output logic               norm_zero_o
);
  import epd_pkg::*;

  fin_state_e  state_d, state_q;
  logic [6:0]  cnt_d, cnt_q;
  logic [15:0] wa_d, wa_q, wb_d, wb_q;
  logic [16:0] wden_d, wden_q, wrem_d, wrem_q;
  logic [37:0] wnum_d, wnum_q;
  logic [21:0] h_d, h_q;
  logic [61:0] wsq_d, wsq_q, wacc_d, wacc_q;
  logic        wz_d, wz_q, nz_d, nz_q, over_d, over_q;
  logic [39:0] sq_d, sq_q, dot_d, dot_q, num_d, num_q;
  logic [38:0] nfa_d, nfa_q;
  logic [62:0] xa_d, xa_q, xb_d, xb_q, ra_d, ra_q, rb_d, rb_q, bit_d, bit_q;
  logic [4:0]  ea_d, ea_q, eb_d, eb_q;
  logic [63:0] dv_d, dv_q, rem_d, rem_q;
  logic [17:0] quo_d, quo_q;

  logic [17:0] wrr;
  logic [62:0] ta, tb;
  logic [64:0] crr;
  logic        cge;
  logic [18:0] qn;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    wa_d    = wa_q;
    wb_d    = wb_q;
    wden_d  = wden_q;
    wrem_d  = wrem_q;
    wnum_d  = wnum_q;
    h_d     = h_q;
    wsq_d   = wsq_q;
    wacc_d  = wacc_q;
    wz_d    = wz_q;
    nz_d    = nz_q;
    over_d  = over_q;
    sq_d    = sq_q;
    dot_d   = dot_q;
    num_d   = num_q;
    nfa_d   = nfa_q;
    xa_d    = xa_q;
    xb_d    = xb_q;
    ra_d    = ra_q;
    rb_d    = rb_q;
    bit_d   = bit_q;
    ea_d    = ea_q;
    eb_d    = eb_q;
    dv_d    = dv_q;
    rem_d   = rem_q;
    quo_d   = quo_q;

    wrr = {wrem_q, wnum_q[37]};
    ta  = ra_q + bit_q;
    tb  = rb_q + bit_q;
    crr = {rem_q, num_q[39]};
    cge = crr >= {1'b0, dv_q};
    qn  = {quo_q, cge};

    unique case (state_q)
      StIdle: begin
        if (load_i) begin
          wa_d    = weight_first_i;
          wb_d    = weight_second_i;
          wden_d  = 17'(weight_first_i) + 17'(weight_second_i);
          wz_d    = (weight_first_i == '0) && (weight_second_i == '0);
          sq_d    = acc_i.sq;
          dot_d   = acc_i.dot;
          nfa_d   = acc_i.na;
          xa_d    = 63'(acc_i.na);
          xb_d    = 63'(acc_i.nb);
          nz_d    = (acc_i.na == '0) || (acc_i.nb == '0);
          ea_d    = '0;
          eb_d    = '0;
          wrem_d  = '0;
          h_d     = '0;
          wacc_d  = '0;
          state_d = StWProd;
        end
      end
      StWProd: begin
        wnum_d  = {32'(wa_q * wb_q), 6'b0};
        cnt_d   = 7'd37;
        state_d = StWDiv;
      end
      StWDiv: begin
        if (wrr >= {1'b0, wden_q}) begin
          wrem_d = 17'(wrr - {1'b0, wden_q});
          h_d    = {h_q[20:0], 1'b1};
        end else begin
          wrem_d = wrr[16:0];
          h_d    = {h_q[20:0], 1'b0};
        end
        wnum_d = {wnum_q[36:0], 1'b0};
        cnt_d  = cnt_q - 7'd1;
        if (cnt_q == '0) begin
          wsq_d   = 62'(sq_q);
          cnt_d   = 7'd21;
          state_d = StWMul;
        end
      end
      StWMul: begin
        if (h_q[0]) begin
          wacc_d = wacc_q + wsq_q;
        end
        h_d   = {1'b0, h_q[21:1]};
        wsq_d = {wsq_q[60:0], 1'b0};
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == '0) begin
          cnt_d   = 7'd30;
          state_d = StNorm;
        end
      end
      StNorm: begin
        if (xa_q[62:61] == 2'b00) begin
          xa_d = {xa_q[60:0], 2'b00};
          ea_d = ea_q + 5'd1;
        end
        if (xb_q[62:61] == 2'b00) begin
          xb_d = {xb_q[60:0], 2'b00};
          eb_d = eb_q + 5'd1;
        end
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == '0) begin
          cnt_d   = 7'd31;
          bit_d   = {1'b1, 62'b0};
          ra_d    = '0;
          rb_d    = '0;
          state_d = StSqrt;
        end
      end
      StSqrt: begin
        if (xa_q >= ta) begin
          xa_d = xa_q - ta;
          ra_d = {1'b0, ra_q[62:1]} + bit_q;
        end else begin
          ra_d = {1'b0, ra_q[62:1]};
        end
        if (xb_q >= tb) begin
          xb_d = xb_q - tb;
          rb_d = {1'b0, rb_q[62:1]} + bit_q;
        end else begin
          rb_d = {1'b0, rb_q[62:1]};
        end
        bit_d = {2'b00, bit_q[62:2]};
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == '0) begin
          state_d = StSMul;
        end
      end
      StSMul: begin
        dv_d    = ra_q[31:0] * rb_q[31:0];
        num_d   = dot_q[39] ? (~dot_q + 40'd1) : dot_q;
        rem_d   = '0;
        quo_d   = '0;
        over_d  = 1'b0;
        cnt_d   = 7'd55 + 7'(ea_q) + 7'(eb_q);
        state_d = StCDiv;
      end
      StCDiv: begin
        rem_d = cge ? 64'(crr - {1'b0, dv_q}) : crr[63:0];
        if (!over_q) begin
          if (qn > 19'(TwoQ16)) begin
            over_d = 1'b1;
          end else begin
            quo_d = qn[17:0];
          end
        end
        num_d = {num_q[38:0], 1'b0};
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == '0) begin
          state_d = StDone;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    wa_q   <= wa_d;
    wb_q   <= wb_d;
    wden_q <= wden_d;
    wrem_q <= wrem_d;
    wnum_q <= wnum_d;
    h_q    <= h_d;
    wsq_q  <= wsq_d;
    wacc_q <= wacc_d;
    wz_q   <= wz_d;
    nz_q   <= nz_d;
    over_q <= over_d;
    sq_q   <= sq_d;
    dot_q  <= dot_d;
    num_q  <= num_d;
    nfa_q  <= nfa_d;
    xa_q   <= xa_d;
    xb_q   <= xb_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    bit_q  <= bit_d;
    ea_q   <= ea_d;
    eb_q   <= eb_d;
    dv_q   <= dv_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  logic [17:0]        t_val;
  logic [18:0]        neg_sum;
  logic signed [39:0] dot_sh;
  logic signed [27:0] unit_w;

  always_comb begin
    t_val   = over_q ? TwoQ16 : quo_q;
    neg_sum = 19'(t_val) + 19'(OneQ16);
    priority if (nz_q) begin
      cosine_dist_o = '0;
    end else if (!dot_q[39]) begin
      cosine_dist_o = (t_val >= OneQ16) ? '0 : 18'(OneQ16 - t_val);
    end else begin
      cosine_dist_o = (neg_sum > 19'(TwoQ16)) ? TwoQ16 : neg_sum[17:0];
    end

    dot_sh = $signed(dot_q) >>> 14;
    unit_w = 28'(OneQ16) - 28'($signed(dot_sh[25:0]));
    priority if (unit_w < 0) begin
      unit_cosine_dist_o = '0;
    end else if (unit_w > 28'(TwoQ16)) begin
      unit_cosine_dist_o = TwoQ16;
    end else begin
      unit_cosine_dist_o = unit_w[17:0];
    end

    priority if (wz_q) begin
      ward_dist_o = '0;
    end else if (wacc_q[61:60] != 2'b00) begin
      ward_dist_o = '1;
    end else begin
      ward_dist_o = wacc_q[59:12];
    end
  end

  assign busy_o            = (state_q != StIdle);
  assign valid_o           = (state_q == StDone);
  assign sq_dist_o         = sq_q;
  assign dot_product_o     = $signed(dot_q);
  assign norm_sq_first_o   = nfa_q;
  assign weight_sum_zero_o = wz_q;
  assign norm_zero_o       = nz_q;

endmodule

[hw/rtl/embedding_pair_distance.sv]
// ----------------------------------------------------------------------------
// embedding_pair_distance
// Squared, Ward and cosine distances between two streamed embedding vectors.
// ----------------------------------------------------------------------------
// Throughput: one element group per cycle while no pair is being finished.
// After the last group is taken, valid_o pulses once the sequencer has divided
//   the weight product, weighted the squared distance, normalized both norms by
//   shifts ea, eb, taken the bit-serial roots and run the cosine long division.
// busy is high from the cycle after the last group until valid_o drops.
// Reset clears the accumulators and the sequencer; the receiver cannot stall.
module embedding_pair_distance (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] first_elem_0_i,
  input  logic signed [15:0] first_elem_1_i,
  input  logic signed [15:0] first_elem_2_i,
  input  logic signed [15:0] first_elem_3_i,
  input  logic signed [15:0] second_elem_0_i,
  input  logic signed [15:0] second_elem_1_i,
  input  logic signed [15:0] second_elem_2_i,
  input  logic signed [15:0] second_elem_3_i,
  input  logic [15:0]        weight_first_i,
  input  logic [15:0]        weight_second_i,
  input  logic               last_group_i,
  output logic               valid_o,
  output logic [39:0]        sq_dist_o,
  output logic [47:0]        ward_dist_o,
  output logic signed [39:0] dot_product_o,
  output logic [38:0]        norm_sq_first_o,
  output logic [17:0]        cosine_dist_o,
  output logic [17:0]        unit_cosine_dist_o,
  output logic               weight_sum_zero_o,
  output logic               norm_zero_o
);
  import epd_pkg::*;

  logic signed [15:0] first_v  [Lanes];
  logic signed [15:0] second_v [Lanes];
  lane_prod_t         prod     [Lanes];
  acc_t               acc;
  logic               accept, fin_busy;
  logic               s1_valid_q, s1_last_q;
  logic [15:0]        s1_wa_q, s1_wb_q;

  assign first_v[0]  = first_elem_0_i;
  assign first_v[1]  = first_elem_1_i;
  assign first_v[2]  = first_elem_2_i;
  assign first_v[3]  = first_elem_3_i;
  assign second_v[0] = second_elem_0_i;
  assign second_v[1] = second_elem_1_i;
  assign second_v[2] = second_elem_2_i;
  assign second_v[3] = second_elem_3_i;

  assign busy   = (s1_valid_q && s1_last_q) || fin_busy;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s1_last_q  <= accept && last_group_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_wa_q <= weight_first_i;
      s1_wb_q <= weight_second_i;
    end
  end

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    epd_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (accept),
      .first_i  (first_v[g]),
      .second_i (second_v[g]),
      .prod_o   (prod[g])
    );
  end

  epd_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .last_i  (s1_last_q),
    .prod_i  (prod),
    .acc_o   (acc)
  );

  epd_final u_final (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (s1_valid_q && s1_last_q),
    .acc_i              (acc),
    .weight_first_i     (s1_wa_q),
    .weight_second_i    (s1_wb_q),
    .busy_o             (fin_busy),
    .valid_o            (valid_o),
    .sq_dist_o          (sq_dist_o),
    .ward_dist_o        (ward_dist_o),
    .dot_product_o      (dot_product_o),
    .norm_sq_first_o    (norm_sq_first_o),
    .cosine_dist_o      (cosine_dist_o),
    .unit_cosine_dist_o (unit_cosine_dist_o),
    .weight_sum_zero_o  (weight_sum_zero_o),
    .norm_zero_o        (norm_zero_o)
  );

endmodule

[bench/epd_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epd_checker
// Watches the group and result channels of the pair distance block, predicts
// every result from the accepted groups and compares field by field.
// ----------------------------------------------------------------------------
module epd_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] first_elem_0_i,
  input  logic signed [15:0] first_elem_1_i,
  input  logic signed [15:0] first_elem_2_i,
  input  logic signed [15:0] first_elem_3_i,
  input  logic signed [15:0] second_elem_0_i,
  input  logic signed [15:0] second_elem_1_i,
  input  logic signed [15:0] second_elem_2_i,
  input  logic signed [15:0] second_elem_3_i,
  input  logic [15:0]        weight_first_i,
  input  logic [15:0]        weight_second_i,
  input  logic               last_group_i,
  input  logic               valid_o,
  input  logic [39:0]        sq_dist_o,
  input  logic [47:0]        ward_dist_o,
  input  logic signed [39:0] dot_product_o,
  input  logic [38:0]        norm_sq_first_o,
  input  logic [17:0]        cosine_dist_o,
  input  logic [17:0]        unit_cosine_dist_o,
  input  logic               weight_sum_zero_o,
  input  logic               norm_zero_o,
  output int                 fail_cnt,
  output int                 pending_cnt,
  output int                 dist_cnt
);
  import epd_pkg::*;

  typedef struct packed {
    logic [39:0] sq;
    logic [47:0] ward;
    logic [39:0] dot;
    logic [38:0] na;
    logic [17:0] cos;
    logic [17:0] ucos;
    logic        wz;
    logic        nz;
  } dist_t;

  dist_t dist_q[$];
  longint unsigned sq_sum, na_sum, nb_sum;
  longint dot_sum;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned root_scaled(longint unsigned n, output int e);
    e = 0;
    while (n < (64'd1 << 61)) begin
      n <<= 2;
      e++;
    end
    return isqrt(n);
  endfunction

  function automatic longint unsigned cos_ratio(longint unsigned n, int sh,
                                                longint unsigned d);
    longint unsigned q, r;
    q = n / d;
    r = n % d;
    if (q > 131072) return 131072;
    for (int i = 0; i < sh; i++) begin
      q <<= 1;
      r <<= 1;
      if (r >= d) begin
        r -= d;
        q |= 1;
      end
      if (q > 131072) return 131072;
    end
    return q;
  endfunction

  task automatic accumulate_group();
    longint a, b, dp;
    longint unsigned sq, na, nb, wa, wb, h, w, mag, sa, sb, t;
    longint ucos;
    int ea, eb;
    dist_t d;
    logic signed [15:0] fa[4], fb[4];
    fa = '{first_elem_0_i, first_elem_1_i, first_elem_2_i, first_elem_3_i};
    fb = '{second_elem_0_i, second_elem_1_i, second_elem_2_i, second_elem_3_i};
    sq = 0; na = 0; nb = 0; dp = 0;
    for (int i = 0; i < Lanes; i++) begin
      a = fa[i];
      b = fb[i];
      sq += (a - b) * (a - b);
      dp += a * b;
      na += a * a;
      nb += b * b;
    end
    sq_sum += sq;
    if (sq_sum > 64'hFF_FFFF_FFFF) sq_sum = 64'hFF_FFFF_FFFF;
    dot_sum += dp;
    if (dot_sum > 64'sd549755813887) dot_sum = 64'sd549755813887;
    if (dot_sum < -64'sd549755813888) dot_sum = -64'sd549755813888;
    na_sum += na;
    if (na_sum > 64'h7F_FFFF_FFFF) na_sum = 64'h7F_FFFF_FFFF;
    nb_sum += nb;
    if (nb_sum > 64'h7F_FFFF_FFFF) nb_sum = 64'h7F_FFFF_FFFF;
    if (!last_group_i) return;
    d = '0;
    wa = weight_first_i;
    wb = weight_second_i;
    if (wa + wb == 0) begin
      d.wz = 1'b1;
    end else begin
      h = (wa * wb * 64) / (wa + wb);
      w = (h * sq_sum) >> 12;
      d.ward = (w > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : w[47:0];
    end
    if (na_sum == 0 || nb_sum == 0) begin
      d.nz = 1'b1;
    end else begin
      sa = root_scaled(na_sum, ea);
      sb = root_scaled(nb_sum, eb);
      mag = dot_sum < 0 ? -dot_sum : dot_sum;
      t = cos_ratio(mag, 16 + ea + eb, sa * sb);
      if (dot_sum >= 0) d.cos = t >= OneQ16 ? 0 : OneQ16 - t;
      else d.cos = (OneQ16 + t > TwoQ16) ? TwoQ16 : OneQ16 + t;
    end
    if (dot_sum >= 0) ucos = 65536 - (dot_sum >>> 14);
    else ucos = 65536 + ((-dot_sum + 16383) >>> 14);
    if (ucos < 0) ucos = 0;
    if (ucos > 131072) ucos = 131072;
    d.ucos = ucos[17:0];
    d.sq = sq_sum[39:0];
    d.dot = dot_sum[39:0];
    d.na = na_sum[38:0];
    dist_q.push_back(d);
    sq_sum = 0; dot_sum = 0; na_sum = 0; nb_sum = 0;
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
    fail_cnt++;
  endtask

  initial begin
    fail_cnt = 0;
    dist_cnt = 0;
    pending_cnt = 0;
    sq_sum = 0; dot_sum = 0; na_sum = 0; nb_sum = 0;
  end

  always @(posedge clk_i) begin
    dist_t e;
    if (rst_ni) begin
      if (valid_o) begin
        dist_cnt++;
        if (dist_q.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          e = dist_q.pop_front();
          if (sq_dist_o !== e.sq) report_mismatch("sq_dist", sq_dist_o, e.sq);
          if (ward_dist_o !== e.ward) report_mismatch("ward_dist", ward_dist_o, e.ward);
          if (dot_product_o !== e.dot) report_mismatch("dot_product", dot_product_o, e.dot);
          if (norm_sq_first_o !== e.na) report_mismatch("norm_sq_first", norm_sq_first_o, e.na);
          if (cosine_dist_o !== e.cos) report_mismatch("cosine_dist", cosine_dist_o, e.cos);
          if (unit_cosine_dist_o !== e.ucos)
            report_mismatch("unit_cosine_dist", unit_cosine_dist_o, e.ucos);
          if (weight_sum_zero_o !== e.wz)
            report_mismatch("weight_sum_zero", weight_sum_zero_o, e.wz);
          if (norm_zero_o !== e.nz) report_mismatch("norm_zero", norm_zero_o, e.nz);
        end
      end
      if (start && !busy) accumulate_group();
    end
    pending_cnt = dist_q.size();
  end

endmodule

[bench/tb_embedding_pair_distance.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_embedding_pair_distance
// Streams directed and random element groups into the pair distance block
// with random gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_embedding_pair_distance;
  import epd_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [15:0] fe[4];
  logic signed [15:0] se[4];
  logic [15:0]        weight_first_i, weight_second_i;
  logic               last_group_i;
  logic               valid_o;
  logic [39:0]        sq_dist_o;
  logic [47:0]        ward_dist_o;
  logic signed [39:0] dot_product_o;
  logic [38:0]        norm_sq_first_o;
  logic [17:0]        cosine_dist_o, unit_cosine_dist_o;
  logic               weight_sum_zero_o, norm_zero_o;
  int                 fail_cnt, pending_cnt, dist_cnt, group_cnt;

  embedding_pair_distance u_top (
    .clk_i, .rst_ni, .start, .busy,
    .first_elem_0_i(fe[0]), .first_elem_1_i(fe[1]),
    .first_elem_2_i(fe[2]), .first_elem_3_i(fe[3]),
    .second_elem_0_i(se[0]), .second_elem_1_i(se[1]),
    .second_elem_2_i(se[2]), .second_elem_3_i(se[3]),
    .weight_first_i, .weight_second_i, .last_group_i,
    .valid_o, .sq_dist_o, .ward_dist_o, .dot_product_o, .norm_sq_first_o,
    .cosine_dist_o, .unit_cosine_dist_o, .weight_sum_zero_o, .norm_zero_o
  );

  epd_checker u_checker (
    .clk_i, .rst_ni, .start, .busy,
    .first_elem_0_i(fe[0]), .first_elem_1_i(fe[1]),
    .first_elem_2_i(fe[2]), .first_elem_3_i(fe[3]),
    .second_elem_0_i(se[0]), .second_elem_1_i(se[1]),
    .second_elem_2_i(se[2]), .second_elem_3_i(se[3]),
    .weight_first_i, .weight_second_i, .last_group_i,
    .valid_o, .sq_dist_o, .ward_dist_o, .dot_product_o, .norm_sq_first_o,
    .cosine_dist_o, .unit_cosine_dist_o, .weight_sum_zero_o, .norm_zero_o,
    .fail_cnt, .pending_cnt, .dist_cnt
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [15:0] pick_elem(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // hold the group on the ports until it is taken; drop start only over a gap
  task automatic send_group(logic [15:0] a[4], logic [15:0] b[4],
                            logic [15:0] wa, logic [15:0] wb, logic lst, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    for (int i = 0; i < 4; i++) begin
      fe[i] <= a[i];
      se[i] <= b[i];
    end
    weight_first_i <= wa;
    weight_second_i <= wb;
    last_group_i <= lst;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    group_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_pair(int len, int amode, int bmode, logic [15:0] wa,
                           logic [15:0] wb, bit gaps);
    logic [15:0] a[4], b[4];
    for (int g = 0; g < len; g++) begin
      for (int i = 0; i < 4; i++) begin
        a[i] = pick_elem(amode);
        b[i] = (bmode == 4) ? -a[i] : (bmode == 5) ? a[i] : pick_elem(bmode);
      end
      send_group(a, b, wa, wb, g == len - 1, gaps);
    end
  endtask

  initial begin
    int len;
    rst_ni = 1'b0;
    start = 1'b0;
    for (int i = 0; i < 4; i++) begin
      fe[i] = '0;
      se[i] = '0;
    end
    weight_first_i = '0;
    weight_second_i = '0;
    last_group_i = 1'b0;
    group_cnt = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, zero norms, zero weights, opposite and equal vectors
    send_pair(1, 0, 0, 16'hFFFF, 16'hFFFF, 0);
    send_pair(1, 1, 0, 16'hFFFF, 16'h0001, 0);
    send_pair(1, 2, 3, 16'h0000, 16'h0000, 0);
    send_pair(1, 2, 2, 16'h0040, 16'h0040, 0);
    send_pair(2, 3, 4, 16'h0000, 16'h0040, 0);
    send_pair(2, 3, 5, 16'h1234, 16'h0000, 0);
    send_pair(1, 1, 1, 16'h8000, 16'h7FFF, 0);
    send_pair(3, 0, 1, 16'hFFFF, 16'hFFFF, 0);
    send_pair(2, 3, 2, 16'h0040, 16'h0080, 0);
    send_pair(1, 3, 3, 16'h0001, 16'h0001, 0);
    // drive accumulators into saturation
    send_pair(130, 0, 0, 16'hFFFF, 16'hFFFF, 0);
    send_pair(130, 0, 1, 16'hFFFF, 16'hFFFF, 0);
    send_pair(130, 0, 0, 16'h0040, 16'h0040, 0);

    while (group_cnt < 600) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
      send_pair(len, $urandom_range(0, 7) < 5 ? 3 : $urandom_range(0, 2),
                $urandom_range(0, 9) < 6 ? 3 : $urandom_range(0, 5),
                $urandom_range(0, 7) == 0 ? 16'h0000 : 16'($urandom),
                $urandom_range(0, 7) == 0 ? 16'h0000 : 16'($urandom), 1);
    end
    start <= 1'b0;

    while (pending_cnt != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Streamed %0d element groups, checked %0d distance results.",
             group_cnt, dist_cnt);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
